@@ design/ffr_pkg.sv @@
// Shared types and constants for the fixed frame receiver.
// No dependencies; the interfaces and the receiver refer to this package by scoped names.
package ffr_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_GOOD     = 2'd0;
  localparam status_t ST_BAD_LEN  = 2'd1;
  localparam status_t ST_BAD_SUM  = 2'd2;
  localparam status_t ST_BAD_TYPE = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_TYPE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMMAND_TYPE = 2'd2;

  localparam logic [9:0] TIMEOUT_RESET      = 10'd200;
  localparam logic [7:0] STATUS_TYPE_RESET  = 8'h00;
  localparam logic [7:0] COMMAND_TYPE_RESET = 8'h01;

  localparam logic [7:0] HEADER_BYTE  = 8'hAA;
  localparam logic [7:0] LENGTH_VALUE = 8'h14;
  localparam logic [9:0] GAP_MAX      = 10'h3FF;

endpackage

@@ design/ffr_if.sv @@
// Handshake channels of the fixed frame receiver: received words in, results out.
// Depends on ffr_pkg for the status type.
interface ffr_rx_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface ffr_res_if;
  logic            valid;
  logic            ready;
  ffr_pkg::status_t status;
  logic [7:0]      frame_byte;
  logic [4:0]      byte_index;
  logic            last;

  modport source (output valid, output status, output frame_byte, output byte_index,
                  output last, input ready);
  modport sink (input valid, input status, input frame_byte, input byte_index,
                input last, output ready);
endinterface

@@ design/ffr_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ffr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 22
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // The read data holds while no read is issued, so a stalled reader keeps it.
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/fixed_frame_receiver.sv @@
// Fixed frame receiver: a tick or a byte that does not finish a frame gives no result.
// The byte that finishes a frame gives a reject result in the next cycle, or starts a
// readout of the frame store that gives one result a cycle unless the result side
// stalls, FRAME_BYTES results in all; each byte is read from the store and then
// registered; the single store read port sets that pace. No word is taken during a readout.
// Reset (rst, synchronous) clears the counters, the sum and the registers to their
// defaults; the frame store is not cleared, as each frame writes it before it is read.
module fixed_frame_receiver #(
  parameter int FRAME_BYTES     = 22,
  parameter int LENGTH_POSITION = 1,
  parameter int TYPE_POSITION   = 2
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ffr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ffr_pkg::CFG_DATA_W-1:0]     cfg_data,
  ffr_rx_if.sink                             rx,
  ffr_res_if.source                          res
);

  localparam int ADDR_W = $clog2(FRAME_BYTES);
  localparam int CNT_W  = $clog2(FRAME_BYTES + 1);
  localparam bit LENGTH_IN = LENGTH_POSITION < FRAME_BYTES;
  localparam bit TYPE_IN   = TYPE_POSITION < FRAME_BYTES;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FRAME_BYTES - 1);
  localparam logic [ADDR_W-1:0] LEN_ADDR  = LENGTH_IN ? ADDR_W'(LENGTH_POSITION) : '0;
  localparam logic [ADDR_W-1:0] TYPE_ADDR = TYPE_IN ? ADDR_W'(TYPE_POSITION) : '0;
  localparam logic [CNT_W-1:0]  CNT_END   = CNT_W'(FRAME_BYTES);
  localparam logic [4:0]        LAST_IDX5 = 5'(FRAME_BYTES - 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  // configuration
  logic [9:0] timeout_ms;
  logic [7:0] status_type_code;
  logic [7:0] command_type_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms        <= ffr_pkg::TIMEOUT_RESET;
      status_type_code  <= ffr_pkg::STATUS_TYPE_RESET;
      command_type_code <= ffr_pkg::COMMAND_TYPE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ffr_pkg::REG_TIMEOUT:      timeout_ms        <= cfg_data;
        ffr_pkg::REG_STATUS_TYPE:  status_type_code  <= cfg_data[7:0];
        ffr_pkg::REG_COMMAND_TYPE: command_type_code <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // frame state
  logic              state, state_next;
  logic [ADDR_W-1:0] fill_count, fill_count_next;
  logic [9:0]        gap_counter, gap_counter_next;
  logic [7:0]        running_sum, running_sum_next;
  logic [7:0]        len_byte, type_byte;
  logic [CNT_W-1:0]  rd_cnt, rd_cnt_next;
  logic              pend_valid, pend_valid_next;
  logic [ADDR_W-1:0] pend_idx;

  logic              out_valid, out_valid_next;
  ffr_pkg::status_t  out_status, out_status_next;
  logic [7:0]        out_byte, out_byte_next;
  logic [4:0]        out_index, out_index_next;
  logic              out_last, out_last_next;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;
  logic [7:0]        rd_data;
  logic              out_free;
  logic              take;
  logic [7:0]        len_now, type_now;
  logic [ADDR_W+4:0] pend_wide;

  assign out_free = !out_valid || res.ready;
  // A stalled result only blocks the word that could finish the next frame.
  assign rx.ready = (state == S_IDLE)
                    && !(out_valid && !res.ready && fill_count == LAST_ADDR);
  assign take = rx.valid && rx.ready;

  assign len_now  = !LENGTH_IN ? 8'h00 : (fill_count == LEN_ADDR ? rx.rx_byte : len_byte);
  assign type_now = !TYPE_IN ? 8'h00 : (fill_count == TYPE_ADDR ? rx.rx_byte : type_byte);

  assign rd_en     = (state == S_EMIT) && (rd_cnt < CNT_END) && (!pend_valid || out_free);
  assign pend_wide = {5'b0, pend_idx};

  always_comb begin
    state_next       = state;
    fill_count_next  = fill_count;
    gap_counter_next = gap_counter;
    running_sum_next = running_sum;
    rd_cnt_next      = rd_cnt;
    pend_valid_next  = pend_valid;
    out_valid_next   = out_valid && !res.ready;
    out_status_next  = out_status;
    out_byte_next    = out_byte;
    out_index_next   = out_index;
    out_last_next    = out_last;
    wr_en            = 1'b0;
    wr_addr          = fill_count;

    if (take) begin
      if (rx.op) begin
        if (gap_counter < ffr_pkg::GAP_MAX) begin
          gap_counter_next = gap_counter + 10'd1;
        end
      end else if (fill_count == '0 || gap_counter > timeout_ms) begin
        // Idle or expired: only a header word opens a frame.
        fill_count_next  = '0;
        running_sum_next = 8'h00;
        if (rx.rx_byte == ffr_pkg::HEADER_BYTE) begin
          wr_en            = 1'b1;
          wr_addr          = '0;
          fill_count_next  = ADDR_W'(1);
          running_sum_next = rx.rx_byte;
          gap_counter_next = 10'd0;
        end
      end else begin
        wr_en            = 1'b1;
        gap_counter_next = 10'd0;
        if (fill_count != LAST_ADDR) begin
          running_sum_next = running_sum + rx.rx_byte;
          fill_count_next  = fill_count + ADDR_W'(1);
        end else begin
          fill_count_next  = '0;
          running_sum_next = 8'h00;
          out_byte_next    = 8'h00;
          out_index_next   = 5'd0;
          out_last_next    = 1'b1;
          if (len_now != ffr_pkg::LENGTH_VALUE) begin
            out_valid_next  = 1'b1;
            out_status_next = ffr_pkg::ST_BAD_LEN;
          end else if (running_sum != rx.rx_byte) begin
            out_valid_next  = 1'b1;
            out_status_next = ffr_pkg::ST_BAD_SUM;
          end else if (type_now != status_type_code && type_now != command_type_code) begin
            out_valid_next  = 1'b1;
            out_status_next = ffr_pkg::ST_BAD_TYPE;
          end else begin
            state_next  = S_EMIT;
            rd_cnt_next = '0;
          end
        end
      end
    end

    if (state == S_EMIT) begin
      if (pend_valid && out_free) begin
        out_valid_next  = 1'b1;
        out_status_next = ffr_pkg::ST_GOOD;
        out_byte_next   = rd_data;
        out_index_next  = pend_wide[4:0];
        out_last_next   = pend_idx == LAST_ADDR;
      end
      if (rd_en) begin
        rd_cnt_next     = rd_cnt + CNT_W'(1);
        pend_valid_next = 1'b1;
      end else if (out_free) begin
        pend_valid_next = 1'b0;
      end
      if (rd_cnt == CNT_END && !pend_valid) begin
        state_next = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fill_count  <= '0;
      gap_counter <= 10'd0;
      running_sum <= 8'h00;
      rd_cnt      <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      fill_count  <= fill_count_next;
      gap_counter <= gap_counter_next;
      running_sum <= running_sum_next;
      rd_cnt      <= rd_cnt_next;
      pend_valid  <= pend_valid_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_status <= out_status_next;
    out_byte   <= out_byte_next;
    out_index  <= out_index_next;
    out_last   <= out_last_next;
    if (rd_en) begin
      pend_idx <= rd_cnt[ADDR_W-1:0];
    end
    // Length and type words are kept aside as they are stored, so the check needs no read.
    if (wr_en && LENGTH_IN && wr_addr == LEN_ADDR) begin
      len_byte <= rx.rx_byte;
    end
    if (wr_en && TYPE_IN && wr_addr == TYPE_ADDR) begin
      type_byte <= rx.rx_byte;
    end
  end

  ffr_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (rx.rx_byte),
    .re    (rd_en),
    .raddr (rd_cnt[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  assign res.valid      = out_valid;
  assign res.status     = out_status;
  assign res.frame_byte = out_byte;
  assign res.byte_index = out_index;
  assign res.last       = out_last;

`ifndef ASSERT_OFF
  a_no_take_in_readout: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> !rx.ready)
    else $error("word accepted during frame readout");

  a_pend_in_readout: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> state == S_EMIT)
    else $error("store read pending outside readout");

  a_reject_shape: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status != ffr_pkg::ST_GOOD |-> res.last && res.frame_byte == 8'h00
                                                     && res.byte_index == 5'd0)
    else $error("reject result malformed");

  a_good_last_index: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status == ffr_pkg::ST_GOOD && res.last |-> res.byte_index == LAST_IDX5)
    else $error("frame readout ends at wrong position");

  a_readout_ends_idle: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.ready && res.status == ffr_pkg::ST_GOOD && res.last |=> state == S_IDLE)
    else $error("readout still active after final word");
`endif

endmodule

@@ test/fixed_frame_receiver_tb.sv @@
// Self-checking testbench for the fixed frame receiver: drives bytes and ticks, predicts
// every result word and checks it. Depends on ffr_pkg, ffr_rx_if, ffr_res_if and the RTL.
module fixed_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_BYTES     = 22;
  localparam int LENGTH_POSITION = 1;
  localparam int TYPE_POSITION   = 2;
  localparam int CYCLE_LIMIT     = 1_000_000;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } rx_word_t;

  typedef struct packed {
    ffr_pkg::status_t status;
    logic [7:0]       frame_byte;
    logic [4:0]       byte_index;
    logic             last;
  } res_word_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [ffr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ffr_pkg::CFG_DATA_W-1:0] cfg_data;

  ffr_rx_if  rx_ch ();
  ffr_res_if res_ch ();

  fixed_frame_receiver #(
    .FRAME_BYTES    (FRAME_BYTES),
    .LENGTH_POSITION(LENGTH_POSITION),
    .TYPE_POSITION  (TYPE_POSITION)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .rx       (rx_ch),
    .res      (res_ch)
  );

  // Pending stimulus words and the result words the receiver still owes.
  rx_word_t  rx_words[$];
  res_word_t due_results[$];

  // Own copy of the receiver state and registers.
  logic [9:0] limit_ms;
  logic [7:0] status_code;
  logic [7:0] command_code;
  logic [7:0] frame_copy [0:63];
  int         filled;
  logic [9:0] gap_ticks;
  logic [7:0] frame_sum;

  int  mismatches = 0;
  int  counted    = 0;
  int  cycles     = 0;
  bit  rx_busy    = 1'b0;
  bit  rx_steady  = 1'b0;
  bit  res_steady = 1'b0;
  int  rx_hold    = 0;
  int  res_hold   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int idle_draw(input bit steady);
    return steady ? 0 : int'($urandom_range(0, 18));
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  function automatic void store_byte(input logic [7:0] b);
    frame_copy[filled[5:0]] = b;
    if (filled < FRAME_BYTES - 1) frame_sum += b;
    filled++;
    gap_ticks = '0;
  endfunction

  function automatic void begin_frame(input logic [7:0] b);
    filled    = 0;
    frame_sum = '0;
    store_byte(b);
  endfunction

  function automatic void push_reject(input ffr_pkg::status_t code);
    due_results.push_back('{code, 8'h00, 5'd0, 1'b1});
  endfunction

  // Advances the state copy by one accepted word and queues the results it causes.
  function automatic void receive_word(input logic op, input logic [7:0] b);
    logic [7:0] len_byte;
    logic [7:0] kind_byte;
    logic [7:0] chk_byte;
    logic [7:0] sum;
    if (op == OP_TICK) begin
      if (gap_ticks < ffr_pkg::GAP_MAX) gap_ticks++;
      return;
    end
    if (filled == 0) begin
      if (b == ffr_pkg::HEADER_BYTE) begin_frame(b);
      return;
    end
    if (gap_ticks > limit_ms) begin
      filled    = 0;
      frame_sum = '0;
      if (b == ffr_pkg::HEADER_BYTE) begin_frame(b);
      return;
    end
    store_byte(b);
    if (filled < FRAME_BYTES) return;
    filled    = 0;
    len_byte  = frame_copy[LENGTH_POSITION & 63];
    kind_byte = frame_copy[TYPE_POSITION & 63];
    chk_byte  = frame_copy[(FRAME_BYTES - 1) & 63];
    sum       = frame_sum;
    frame_sum = '0;
    if (len_byte != ffr_pkg::LENGTH_VALUE) begin
      push_reject(ffr_pkg::ST_BAD_LEN);
    end else if (sum != chk_byte) begin
      push_reject(ffr_pkg::ST_BAD_SUM);
    end else if (kind_byte != status_code && kind_byte != command_code) begin
      push_reject(ffr_pkg::ST_BAD_TYPE);
    end else begin
      for (int i = 0; i < FRAME_BYTES; i++)
        due_results.push_back('{ffr_pkg::ST_GOOD, frame_copy[i & 63], 5'(i),
                                i == FRAME_BYTES - 1});
    end
  endfunction

  task automatic push_word(input logic op, input logic [7:0] b, input bit counts);
    rx_words.push_back('{op, b});
    if (counts) counted++;
  endtask

  // The byte field of a tick is ignored, so it carries random bits.
  task automatic push_ticks(input int n, input bit counts);
    repeat (n) push_word(OP_TICK, 8'($urandom), counts);
  endtask

  // A header followed by a few random bytes, never enough to complete a frame.
  task automatic queue_stub(input int n);
    push_word(OP_BYTE, ffr_pkg::HEADER_BYTE, 1'b1);
    repeat (n) push_word(OP_BYTE, 8'($urandom), 1'b1);
  endtask

  // Queues one frame. A fill of -1 gives a random body. A hole puts hole_ticks ticks
  // before byte hole_at; elsewhere short runs of ticks stay within the timeout.
  task automatic queue_frame(input logic [7:0] kind, input bit bad_len, input bit bad_sum,
                             input int fill, input int hole_at, input int hole_ticks,
                             input int tick_pct);
    logic [7:0] fb [FRAME_BYTES];
    logic [7:0] sum;
    int         quiet;
    sum   = '0;
    fb[0] = ffr_pkg::HEADER_BYTE;
    fb[1] = ffr_pkg::LENGTH_VALUE;
    if (bad_len) begin
      do fb[1] = 8'($urandom); while (fb[1] == ffr_pkg::LENGTH_VALUE);
    end
    fb[2] = kind;
    for (int i = 3; i < FRAME_BYTES - 1; i++)
      fb[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
    for (int i = 0; i < FRAME_BYTES - 1; i++) sum += fb[i];
    fb[FRAME_BYTES - 1] = bad_sum ? 8'(sum + $urandom_range(1, 255)) : sum;
    quiet = (limit_ms < 3) ? int'(limit_ms) : 3;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if (i > 0 && i == hole_at) begin
        push_ticks(hole_ticks, 1'b1);
      end else if (i > 0 && quiet > 0 && $urandom_range(0, 99) < tick_pct) begin
        push_ticks($urandom_range(1, quiet), 1'b1);
      end
      push_word(OP_BYTE, fb[i], 1'b1);
    end
  endtask

  // Mostly well-formed frames; some noise, cut-short frames and frames broken by a long
  // gap. After anything that may leave a partial frame, a gap past the timeout puts the
  // receiver back in step. That cannot work with the largest timeout, so there only
  // frames are sent.
  task automatic run_traffic(input int budget);
    int         start;
    int         pick;
    int         hole;
    int         r;
    logic [7:0] kind;
    start = counted;
    while (counted - start < budget) begin
      pick = $urandom_range(0, 99);
      if (limit_ms == ffr_pkg::GAP_MAX || pick < 70) begin
        r    = $urandom_range(0, 19);
        kind = (r < 9) ? status_code : (r < 18) ? command_code : 8'($urandom);
        hole = 0;
        if (limit_ms != ffr_pkg::GAP_MAX && $urandom_range(0, 19) == 0)
          hole = $urandom_range(1, 21);
        queue_frame(kind, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0, -1,
                    hole, int'(limit_ms) + 1, 25);
        if (hole != 0) push_ticks(int'(limit_ms) + 1, 1'b0);
        if ($urandom_range(0, 9) < 3) push_ticks($urandom_range(1, 3), 1'b1);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) push_word(1'($urandom), 8'($urandom), 1'b1);
        push_ticks(int'(limit_ms) + 1, 1'b0);
      end else begin
        queue_stub($urandom_range(1, 20));
        push_ticks(int'(limit_ms) + 1, 1'b0);
      end
    end
  endtask

  task automatic write_reg(input logic [ffr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ffr_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ffr_pkg::REG_TIMEOUT:      limit_ms     = val[9:0];
      ffr_pkg::REG_STATUS_TYPE:  status_code  = val[7:0];
      ffr_pkg::REG_COMMAND_TYPE: command_code = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [9:0] t, input logic [7:0] s, input logic [7:0] c);
    write_reg(ffr_pkg::REG_TIMEOUT, t);
    write_reg(ffr_pkg::REG_STATUS_TYPE, ffr_pkg::CFG_DATA_W'(s));
    write_reg(ffr_pkg::REG_COMMAND_TYPE, ffr_pkg::CFG_DATA_W'(c));
  endtask

  // Sampled on the falling edge, once the rising-edge updates have settled.
  task automatic wait_idle(input int settle);
    do @(negedge clk);
    while (rx_words.size() != 0 || rx_busy || due_results.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  // Driver: presents pending words after a drawn gap and stalls the result side.
  always @(posedge clk) begin
    rx_word_t w;
    if (rst) begin
      rx_ch.valid  <= 1'b0;
      res_ch.ready <= 1'b0;
      rx_busy  = 1'b0;
      rx_hold  = 0;
      res_hold = 0;
    end else begin
      if (rx_busy && rx_ch.ready) rx_busy = 1'b0;
      if (!rx_busy) begin
        if (rx_hold > 0) begin
          rx_hold--;
        end else if (rx_words.size() > 0) begin
          w = rx_words.pop_front();
          rx_ch.op      <= w.op;
          rx_ch.rx_byte <= w.data;
          rx_busy = 1'b1;
          if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
          rx_hold = idle_draw(rx_steady);
        end
      end
      rx_ch.valid <= rx_busy;

      if (res_ch.valid && res_ch.ready) begin
        if ($urandom_range(0, 39) == 0) res_steady = !res_steady;
        res_hold = idle_draw(res_steady);
      end
      if (res_hold > 0) begin
        res_hold--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: every accepted word updates the prediction, every result word is checked.
  always @(posedge clk) begin
    res_word_t seen;
    res_word_t want;
    if (!rst) begin
      if (rx_ch.valid && rx_ch.ready) receive_word(rx_ch.op, rx_ch.rx_byte);
      if (res_ch.valid && res_ch.ready) begin
        seen = '{res_ch.status, res_ch.frame_byte, res_ch.byte_index, res_ch.last};
        if (due_results.size() == 0) begin
          flag_error($sformatf("unexpected result: status %0d byte %02h index %0d last %0b",
                               seen.status, seen.frame_byte, seen.byte_index, seen.last));
        end else begin
          want = due_results.pop_front();
          if (seen.status !== want.status || seen.frame_byte !== want.frame_byte ||
              seen.byte_index !== want.byte_index || seen.last !== want.last)
            flag_error($sformatf(
              "mismatch: expected status %0d byte %02h index %0d last %0b, got %0d %02h %0d %0b",
              want.status, want.frame_byte, want.byte_index, want.last,
              seen.status, seen.frame_byte, seen.byte_index, seen.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [7:0] code;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    rx_ch.valid   = 1'b0;
    rx_ch.op      = OP_BYTE;
    rx_ch.rx_byte = 8'h00;
    res_ch.ready  = 1'b0;
    limit_ms      = ffr_pkg::TIMEOUT_RESET;
    status_code   = ffr_pkg::STATUS_TYPE_RESET;
    command_code  = ffr_pkg::COMMAND_TYPE_RESET;
    filled        = 0;
    gap_ticks     = '0;
    frame_sum     = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Register values straight out of reset.
    push_word(OP_BYTE, 8'h55, 1'b1);
    push_word(OP_TICK, 8'hFF, 1'b1);
    queue_frame(status_code, 1'b0, 1'b0, 8'h00, 0, 0, 0);
    queue_frame(command_code, 1'b0, 1'b0, 8'hFF, 0, 0, 0);
    queue_frame(status_code, 1'b1, 1'b1, -1, 0, 0, 0);
    queue_frame(8'h77, 1'b0, 1'b1, -1, 0, 0, 0);
    queue_frame(8'h77, 1'b0, 1'b0, -1, 0, 0, 0);

    // A short timeout keeps the gaps short. A gap equal to the timeout survives; one tick
    // more breaks the frame.
    wait_idle(4);
    set_regs(10'd4, ffr_pkg::STATUS_TYPE_RESET, ffr_pkg::COMMAND_TYPE_RESET);
    queue_frame(command_code, 1'b0, 1'b0, -1, 7, int'(limit_ms), 0);
    queue_frame(status_code, 1'b0, 1'b0, -1, 12, int'(limit_ms) + 1, 0);
    push_ticks(int'(limit_ms) + 1, 1'b0);
    // An expired header starts a new frame; any other expired byte is dropped.
    queue_stub(5);
    push_ticks(int'(limit_ms) + 1, 1'b0);
    queue_frame(status_code, 1'b0, 1'b0, -1, 0, 0, 0);
    queue_stub(5);
    push_ticks(int'(limit_ms) + 1, 1'b0);
    push_word(OP_BYTE, 8'h3C, 1'b1);
    queue_frame(command_code, 1'b0, 1'b0, -1, 0, 0, 0);

    // Largest timeout: no gap can expire a frame, so only whole frames are sent.
    wait_idle(4);
    set_regs(ffr_pkg::GAP_MAX, 8'h5A, 8'hA5);
    run_traffic(22);

    // Zero timeout: a single tick inside a frame expires it.
    wait_idle(4);
    set_regs(10'd0, 8'hFF, 8'h00);
    queue_frame(8'hFF, 1'b0, 1'b0, -1, 0, 0, 0);
    queue_frame(8'h00, 1'b0, 1'b0, -1, 0, 0, 0);
    queue_frame(8'hFF, 1'b0, 1'b0, -1, 9, 1, 0);
    push_ticks(1, 1'b0);
    run_traffic(15);

    wait_idle(4);
    set_regs(10'd1, 8'($urandom), 8'($urandom));
    run_traffic(25);

    wait_idle(4);
    code = 8'($urandom);
    set_regs(10'($urandom_range(2, 8)), code,
             ($urandom_range(0, 3) == 0) ? code : 8'($urandom));
    run_traffic(25);

    wait_idle(40);
    if (due_results.size() != 0)
      flag_error($sformatf("%0d expected results never arrived", due_results.size()));
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
